// ===== design/ttst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_pkg
// Shared types and constants for the task tick scheduler table.
// ----------------------------------------------------------------------------
package ttst_pkg;

  // slot count used when the top level is not overridden
  localparam int unsigned TASKS_DEFAULT = 16;
  // most dispatch results that one item may cause
  localparam int unsigned MAX_RESULTS   = 16;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned TASK_ID_W  = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SLOT_IDX_W = 5;
  localparam int unsigned PEND_W     = 8;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // one stored slot, the occupied mark lives in flip-flops beside the ram
  typedef struct packed {
    logic [TASK_ID_W-1:0] ident;
    logic [TIME_W-1:0]    delay;
    logic [TIME_W-1:0]    period;
    logic [PEND_W-1:0]    pending;
  } slot_t;

  // one result item without its last flag
  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TASK_ID_W-1:0]  ran_task;
    logic                  ran_valid;
    logic [STATUS_W-1:0]   status;
  } res_t;

endpackage

// ===== design/ttst_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_in_if
// Command channel of the scheduler table: valid/ready and one item.
// ----------------------------------------------------------------------------
interface ttst_in_if;
  import ttst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [TASK_ID_W-1:0] task_id;
  logic [TIME_W-1:0]    first_delay;
  logic [TIME_W-1:0]    repeat_period;
  logic [SLOT_W-1:0]    slot;

  modport source (
    output valid, kind, task_id, first_delay, repeat_period, slot,
    input  ready
  );

  modport sink (
    input  valid, kind, task_id, first_delay, repeat_period, slot,
    output ready
  );

endinterface

// ===== design/ttst_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_out_if
// Result channel of the scheduler table: valid/ready and one item.
// ----------------------------------------------------------------------------
interface ttst_out_if;
  import ttst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [TASK_ID_W-1:0]  ran_task;
  logic                  ran_valid;
  logic [STATUS_W-1:0]   status;
  logic                  last;

  modport source (
    output valid, slot_index, ran_task, ran_valid, status, last,
    input  ready
  );

  modport sink (
    input  valid, slot_index, ran_task, ran_valid, status, last,
    output ready
  );

endinterface

// ===== design/ttst_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttst_slot_ram #(
  parameter int unsigned DEPTH = ttst_pkg::TASKS_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ttst_pkg::slot_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ttst_pkg::slot_t rdata_o
);
  import ttst_pkg::*;

  slot_t mem_q [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/task_tick_scheduler_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_tick_scheduler_table
// Table of periodic and one-shot task slots driven by tick, add, delete and
// dispatch items.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Slot contents sit in a single-port-read
// synchronous ram, occupied marks in flip-flops (reset clears every mark),
// so no clearing pass follows reset. A tick walks every slot through a
// read/modify/write pipeline; an add scans the occupied marks one slot a
// cycle; a delete is settled when it is taken; a dispatch reads each slot
// visited and then checks it, stops at its result budget, and may stall while
// the result side is busy. Results pass through an output register, so the
// next item is taken while the last result still waits.
// ----------------------------------------------------------------------------
module task_tick_scheduler_table #(
  parameter int unsigned TASKS = ttst_pkg::TASKS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttst_in_if.sink    in_i,
  ttst_out_if.source out_o
);
  import ttst_pkg::*;

  localparam int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(TASKS + 1);
  localparam int unsigned NDS_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned XW    = IDX_W + SLOT_IDX_W + SLOT_W;
  localparam int unsigned FULL_IDX = TASKS % (1 << SLOT_IDX_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ADD,
    ST_DISP_RD,
    ST_DISP_CHK,
    ST_FLUSH
  } state_e;

  function automatic logic [SLOT_IDX_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    logic [XW-1:0] w;
    w = XW'(i);
    return w[SLOT_IDX_W-1:0];
  endfunction

  state_e st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;
  logic p_vld_q, p_vld_d;
  logic [NDS_W-1:0] ndisp_q, ndisp_d;
  logic [TASKS-1:0] occ_q, occ_d;
  res_t hold_q, hold_d;
  logic hold_vld_q, hold_vld_d;
  res_t out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic out_last_q, out_last_d;
  logic [TASK_ID_W-1:0] a_id_q, a_id_d;
  logic [TIME_W-1:0] a_delay_q, a_delay_d;
  logic [TIME_W-1:0] a_period_q, a_period_d;

  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t ram_wdata, ram_rdata;

  logic out_free;
  logic [IDX_W-1:0] cnt_idx;
  logic [XW-1:0] sl_ext;
  logic [IDX_W-1:0] sl_idx;
  logic disp_ready;

  ttst_slot_ram #(
    .DEPTH(TASKS),
    .AW   (IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_vld_q || out_o.ready;
  assign cnt_idx    = cnt_q[IDX_W-1:0];
  assign sl_ext     = XW'(in_i.slot);
  assign sl_idx     = sl_ext[IDX_W-1:0];
  assign disp_ready = occ_q[p_idx_q] && (ram_rdata.pending != '0);

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    p_idx_d    = p_idx_q;
    p_vld_d    = 1'b0;
    ndisp_d    = ndisp_q;
    occ_d      = occ_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    out_last_d = out_last_q;
    a_id_d     = a_id_q;
    a_delay_d  = a_delay_q;
    a_period_d = a_period_q;
    ram_we     = 1'b0;
    ram_waddr  = p_idx_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = cnt_idx;

    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cnt_d      = '0;
          ndisp_d    = '0;
          hold_d     = '0;
          hold_vld_d = 1'b0;
          a_id_d     = in_i.task_id;
          a_delay_d  = in_i.first_delay;
          a_period_d = in_i.repeat_period;
          case (kind_e'(in_i.kind))
            KIND_TICK:     st_d = ST_TICK;
            KIND_ADD:      st_d = ST_ADD;
            KIND_DISPATCH: st_d = ST_DISP_RD;
            KIND_DELETE: begin
              hold_d.slot_index = SLOT_IDX_W'(in_i.slot);
              hold_d.status     = STATUS_EMPTY;
              if (sl_ext < XW'(TASKS)) begin
                if (occ_q[sl_idx]) begin
                  hold_d.status = STATUS_OK;
                end
                occ_d[sl_idx] = 1'b0;
              end
              st_d = ST_FLUSH;
            end
            default: st_d = ST_FLUSH;
          endcase
        end
      end

      ST_TICK: begin
        // write stage works on the slot read in the previous cycle
        if (p_vld_q) begin
          ram_we = occ_q[p_idx_q];
          if (ram_rdata.delay == '0) begin
            if (ram_rdata.pending != {PEND_W{1'b1}}) begin
              ram_wdata.pending = ram_rdata.pending + 1'b1;
            end
            if (ram_rdata.period != '0) begin
              ram_wdata.delay = ram_rdata.period;
            end
          end else begin
            ram_wdata.delay = ram_rdata.delay - 1'b1;
          end
        end
        if (cnt_q != CNT_W'(TASKS)) begin
          ram_re  = 1'b1;
          p_vld_d = 1'b1;
          p_idx_d = cnt_idx;
          cnt_d   = cnt_q + 1'b1;
        end else if (!p_vld_q) begin
          st_d = ST_FLUSH;
        end
      end

      ST_ADD: begin
        if (!occ_q[cnt_idx]) begin
          ram_we            = 1'b1;
          ram_waddr         = cnt_idx;
          ram_wdata.ident   = a_id_q;
          ram_wdata.delay   = a_delay_q;
          ram_wdata.period  = a_period_q;
          ram_wdata.pending = '0;
          occ_d[cnt_idx]    = 1'b1;
          hold_d.slot_index = to_slot(cnt_idx);
          hold_d.status     = STATUS_OK;
          st_d              = ST_FLUSH;
        end else if (cnt_q == CNT_W'(TASKS - 1)) begin
          hold_d.slot_index = SLOT_IDX_W'(FULL_IDX);
          hold_d.status     = STATUS_FULL;
          st_d              = ST_FLUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DISP_RD: begin
        if (cnt_q == CNT_W'(TASKS) || ndisp_q == NDS_W'(MAX_RESULTS)) begin
          st_d = ST_FLUSH;
        end else begin
          ram_re  = 1'b1;
          p_idx_d = cnt_idx;
          st_d    = ST_DISP_CHK;
        end
      end

      ST_DISP_CHK: begin
        if (!disp_ready) begin
          cnt_d = cnt_q + 1'b1;
          st_d  = ST_DISP_RD;
        end else if (!hold_vld_q || out_free) begin
          // a later ready slot proves the held item is not the last one
          if (hold_vld_q) begin
            out_vld_d  = 1'b1;
            out_d      = hold_q;
            out_last_d = 1'b0;
          end
          hold_d.slot_index = to_slot(p_idx_q);
          hold_d.ran_task   = ram_rdata.ident;
          hold_d.ran_valid  = 1'b1;
          hold_d.status     = STATUS_OK;
          hold_vld_d        = 1'b1;
          ndisp_d           = ndisp_q + 1'b1;
          ram_we            = 1'b1;
          ram_wdata.pending = ram_rdata.pending - 1'b1;
          if (ram_rdata.period == '0) begin
            occ_d[p_idx_q] = 1'b0;
          end
          cnt_d = cnt_q + 1'b1;
          st_d  = ST_DISP_RD;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = hold_q;
          out_last_d = 1'b1;
          st_d       = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      cnt_q      <= '0;
      p_idx_q    <= '0;
      p_vld_q    <= 1'b0;
      ndisp_q    <= '0;
      occ_q      <= '0;
      hold_q     <= '0;
      hold_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      a_id_q     <= '0;
      a_delay_q  <= '0;
      a_period_q <= '0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      p_idx_q    <= p_idx_d;
      p_vld_q    <= p_vld_d;
      ndisp_q    <= ndisp_d;
      occ_q      <= occ_d;
      hold_q     <= hold_d;
      hold_vld_q <= hold_vld_d;
      out_q      <= out_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
      a_id_q     <= a_id_d;
      a_delay_q  <= a_delay_d;
      a_period_q <= a_period_d;
    end
  end

  assign in_i.ready       = (st_q == ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.slot_index = out_q.slot_index;
  assign out_o.ran_task   = out_q.ran_task;
  assign out_o.ran_valid  = out_q.ran_valid;
  assign out_o.status     = out_q.status;
  assign out_o.last       = out_last_q;

`ifndef SYNTHESIS
  // dispatch never goes past its result budget
  a_disp_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndisp_q <= NDS_W'(MAX_RESULTS))
    else $error("dispatch count past its budget");

  // the slot ram is never read and written at the same entry at once, in the tick pipeline or elsewhere
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot ram read and write hit the same entry");

  // an accepted item closes the input until its work is done
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input open straight after an accepted item");

  // a tick leaves the occupied marks alone
  a_tick_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_TICK) |=> $stable(occ_q))
    else $error("occupied marks changed during a tick");
`endif

endmodule
